// ===== hdl/swm_pkg.sv =====
// Package for the sliding window median filter.
// Holds the register constants, queue sizing and the control and status structs.
// No dependencies.
package swm_pkg;

   localparam int CSR_WIDTH = 7;
   localparam logic [CSR_WIDTH-1:0] WINDOW_RESET = 7'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_CNT_WIDTH = 3;

   typedef struct packed {
      logic insert;
      logic flush;
      logic full;
   } sort_ctrl_type;

   typedef struct packed {
      logic full;
      logic last_slot;
   } queue_status_type;

endpackage

// ===== hdl/swm_sample_if.sv =====
// Input channel of the median filter: one signed sample per item.
// Depends on nothing.
interface swm_sample_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/swm_median_if.sv =====
// Result channel of the median filter: one signed lower median per item.
// Depends on nothing.
interface swm_median_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

// ===== hdl/swm_sort_array.sv =====
// Sorted window of samples held in a row of cells, each with a key and an age.
// Each insert evicts the oldest cell (when full) and places the new sample in order.
// Depends on swm_pkg.
module swm_sort_array
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int WW           = $clog2(WINDOW_MAX + 1),
   parameter int AW           = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sort_ctrl_type                  ctrl,
   input  logic [WW-1:0]                  window,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic [AW-1:0]                  mid_index,
   output logic signed [SAMPLE_WIDTH-1:0] mid_value
);

   localparam int N = WINDOW_MAX;

   logic [N-1:0]                  valid_ff;
   logic [N-1:0]                  valid_in;
   logic signed [SAMPLE_WIDTH-1:0] key_ff [N];
   logic signed [SAMPLE_WIDTH-1:0] key_in [N];
   logic [AW-1:0]                 age_ff [N];
   logic [AW-1:0]                 age_in [N];

   logic [N-1:0]                  evict;
   logic [N-1:0]                  greater;
   logic [N-1:0]                  removed_at_or_below;
   logic [N-1:0]                  c_valid;
   logic [N-1:0]                  c_greater;
   logic signed [SAMPLE_WIDTH-1:0] c_key [N];
   logic [AW-1:0]                 c_age [N];
   logic [AW-1:0]                 evict_age;

   assign evict_age = AW'(window - 1'b1);

   // mark the oldest cell and the cells whose key sorts after the new sample
   always_comb begin
      for (int i = 0; i < N; i++) begin
         evict[i]   = ctrl.full && valid_ff[i] && (age_ff[i] == evict_age);
         greater[i] = !valid_ff[i] || (key_ff[i] > sample);
      end
   end

   // close the gap left by the evicted cell
   always_comb begin
      for (int i = 0; i < N; i++) begin
         removed_at_or_below[i] = |(evict << (N - 1 - i));
      end
      for (int i = 0; i < N; i++) begin
         if (!removed_at_or_below[i]) begin
            c_valid[i]   = valid_ff[i];
            c_greater[i] = greater[i];
            c_key[i]     = key_ff[i];
            c_age[i]     = age_ff[i];
         end else if (i < N - 1) begin
            c_valid[i]   = valid_ff[(i < N - 1) ? i + 1 : i];
            c_greater[i] = greater[(i < N - 1) ? i + 1 : i];
            c_key[i]     = key_ff[(i < N - 1) ? i + 1 : i];
            c_age[i]     = age_ff[(i < N - 1) ? i + 1 : i];
         end else begin
            c_valid[i]   = 1'b0;
            c_greater[i] = 1'b1;
            c_key[i]     = key_ff[i];
            c_age[i]     = age_ff[i];
         end
      end
   end

   // open a slot at the insertion point and age every cell
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (!c_greater[i]) begin
            valid_in[i] = c_valid[i];
            key_in[i]   = c_key[i];
            age_in[i]   = c_age[i] + 1'b1;
         end else if (i > 0 && c_greater[(i > 0) ? i - 1 : 0]) begin
            valid_in[i] = c_valid[(i > 0) ? i - 1 : 0];
            key_in[i]   = c_key[(i > 0) ? i - 1 : 0];
            age_in[i]   = c_age[(i > 0) ? i - 1 : 0] + 1'b1;
         end else begin
            valid_in[i] = 1'b1;
            key_in[i]   = sample;
            age_in[i]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.flush) begin
         valid_ff <= '0;
      end else if (ctrl.insert) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert && !ctrl.flush) begin
         for (int i = 0; i < N; i++) begin
            key_ff[i] <= key_in[i];
            age_ff[i] <= age_in[i];
         end
      end
   end

   assign mid_value = key_ff[mid_index];

   a_one_evict : assert property (@(posedge clock) disable iff (reset)
      $onehot0(evict))
      else $error("more than one cell marked for eviction");

   a_full_evicts : assert property (@(posedge clock) disable iff (reset)
      ctrl.insert && ctrl.full |-> $onehot(evict))
      else $error("full window insert without an eviction");

   a_sorted_fill : assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> valid_ff == '0)
      else $error("valid cells not packed at the low end");

endmodule

// ===== hdl/swm_out_queue.sv =====
// Small result queue that decouples the filter from a stalled consumer.
// Drives the result channel and reports when it is full or has one slot left.
// Depends on swm_pkg and swm_median_if.
module swm_out_queue
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic signed [SAMPLE_WIDTH-1:0] push_data,
   output queue_status_type               status,
   swm_median_if.source                   rsp_chan
);

   logic signed [SAMPLE_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]     head_ff;
   logic [QUEUE_PTR_WIDTH-1:0]     head_in;
   logic [QUEUE_PTR_WIDTH-1:0]     tail_ff;
   logic [QUEUE_PTR_WIDTH-1:0]     tail_in;
   logic [QUEUE_CNT_WIDTH-1:0]     count_ff;
   logic [QUEUE_CNT_WIDTH-1:0]     count_in;
   logic                           pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign rsp_chan.valid   = (count_ff != '0);
   assign rsp_chan.median  = slot_ff[head_ff];
   assign status.full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign status.last_slot = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 1));

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("push into a full result queue");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 || count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH) ||
      head_ff != tail_ff)
      else $error("queue pointers disagree with count");

endmodule

// ===== hdl/sliding_window_median.sv =====
// Sliding window lower median filter: one sample per item, one median per item once full.
// An accepted sample updates the cell array and the pending flag; its median then enters the result queue.
// Throughput: one item per cycle while the result queue has room; a 4-entry result queue absorbs consumer stalls.
// Cell array of WINDOW_MAX sorted entries updates in the accept cycle; median read next cycle.
// Reset (synchronous): window_size 3, window empty, queue empty; a window_size write empties
// the window.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   swm_sample_if.sink           req_chan,
   swm_median_if.source         rsp_chan
);

   localparam int WW = $clog2(WINDOW_MAX + 1);
   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [CSR_WIDTH-1:0]           window_ff;
   logic [WW-1:0]                  window_eff;
   logic [WW-1:0]                  fill_ff;
   logic [WW-1:0]                  fill_in;
   logic                           pend_ff;
   logic                           pend_in;
   logic                           accept;
   logic                           full;
   logic                           produce;
   logic [AW-1:0]                  mid_index;
   logic signed [SAMPLE_WIDTH-1:0] mid_value;
   sort_ctrl_type                  sort_ctrl;
   queue_status_type               q_status;

   always_comb begin
      if (window_ff == '0) begin
         window_eff = WW'(1);
      end else if (int'(window_ff) > WINDOW_MAX) begin
         window_eff = WW'(WINDOW_MAX);
      end else begin
         window_eff = WW'(window_ff);
      end
   end

   assign req_chan.ready = !q_status.full && !(q_status.last_slot && pend_ff);
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (fill_ff >= window_eff);
   assign produce        = ({1'b0, fill_ff} + 1'b1) >= {1'b0, window_eff};
   assign mid_index      = AW'((window_eff - 1'b1) >> 1);

   always_comb begin
      fill_in = fill_ff;
      if (csr_we) begin
         fill_in = '0;
      end else if (accept && !full) begin
         fill_in = fill_ff + 1'b1;
      end
      pend_in = accept && produce && !csr_we;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   assign sort_ctrl.insert = accept;
   assign sort_ctrl.flush  = csr_we;
   assign sort_ctrl.full   = full;

   swm_sort_array #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .WW           (WW),
      .AW           (AW)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sort_ctrl),
      .window    (window_eff),
      .sample    (req_chan.sample),
      .mid_index (mid_index),
      .mid_value (mid_value)
   );

   swm_out_queue #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pend_ff),
      .push_data (mid_value),
      .status    (q_status),
      .rsp_chan  (rsp_chan)
   );

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= window_eff)
      else $error("fill count above window size");

   a_pend_full : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> fill_ff == window_eff)
      else $error("median read from a window that is not full");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !$past(q_status.full))
      else $error("result pending while the queue was full");

endmodule

// ===== bench/swm_median_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sliding window median filter: mirrors the sample history
// and window size, predicts each lower median and compares the result channel.
// Depends on swm_pkg for the window register width and its reset value.
module swm_median_checker
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [CSR_WIDTH-1:0]           csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   output int                             outstanding,
   output int                             mismatches
);
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   sample_type           history [WINDOW_MAX];
   int                   head;
   int                   filled;
   int                   errors = 0;
   logic [CSR_WIDTH-1:0] window_reg;
   sample_type           expected_medians [$];

   // register value to the window length actually used
   function automatic int window_span(input logic [CSR_WIDTH-1:0] raw);
      if (raw == 0) return 1;
      if (raw > WINDOW_MAX) return WINDOW_MAX;
      return int'(raw);
   endfunction

   // lower median of the newest w samples in the history
   function automatic sample_type lower_median(input int w);
      sample_type ordered [WINDOW_MAX];
      sample_type key;
      int         pos;
      int         j;
      pos = head;
      for (int i = 0; i < w; i++) begin
         pos = (pos == 0) ? WINDOW_MAX - 1 : pos - 1;
         ordered[i] = history[pos];
      end
      for (int i = 1; i < w; i++) begin
         key = ordered[i];
         j = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      return ordered[(w - 1) / 2];
   endfunction

   always @(posedge clock) begin
      sample_type want;
      int         w;
      if (reset) begin
         window_reg = WINDOW_RESET;
         head = 0;
         filled = 0;
         expected_medians.delete();
      end else begin
         if (csr_we) begin
            window_reg = csr_wdata;
            filled = 0;
         end
         if (req_valid && req_ready) begin
            w = window_span(window_reg);
            history[head] = req_sample;
            head = (head + 1) % WINDOW_MAX;
            if (filled < w) filled++;
            if (filled >= w) expected_medians = {expected_medians, lower_median(w)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_medians.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("median with nothing expected: got %0d", rsp_median);
            end else begin
               want = expected_medians.pop_front();
               if (rsp_median !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("median mismatch: expected %0d got %0d", want, rsp_median);
               end
            end
         end
      end
      outstanding <= expected_medians.size();
      mismatches  <= errors;
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Bench top for the sliding window median filter: clock, reset, sample stimulus in
// phases of window size and flow control, result back-pressure and the verdict.
// Depends on swm_pkg, swm_sample_if, swm_median_if, the filter and swm_median_checker.
module tb_top
   import swm_pkg::*;
();

   localparam int WINDOW_MAX    = 64;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 12;
   localparam int FIXED_PHASES  = 10;
   localparam int PAUSE_PHASE   = 4;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef enum int {FLOW_FREE, FLOW_SLOW_SENDER, FLOW_SLOW_RECEIVER, FLOW_BOTH} flow_mode_type;

   localparam sample_type EDGE_SAMPLES [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                               16'sh0001, 16'sh8000, 16'sh8000, 16'sh7FFF};
   localparam sample_type SINGLE_SAMPLES [4] = '{16'sh8000, 16'sh7FFF, 16'sh5555, 16'shAAAA};
   localparam sample_type PAIR_SAMPLES [5] = '{16'sd5, 16'sd5, -16'sd7, 16'sh7FFF, 16'sh8000};

   localparam int PHASE_WINDOW [FIXED_PHASES] = '{64, 127, 1, 4, 65, 2, 5, 42, 85, 7};
   localparam flow_mode_type PHASE_FLOW [PHASES] = '{
      FLOW_FREE, FLOW_SLOW_SENDER, FLOW_SLOW_RECEIVER, FLOW_BOTH,
      FLOW_FREE, FLOW_SLOW_SENDER, FLOW_SLOW_RECEIVER, FLOW_BOTH,
      FLOW_SLOW_RECEIVER, FLOW_FREE, FLOW_BOTH, FLOW_SLOW_SENDER};
   localparam int PHASE_ITEMS [PHASES] = '{200, 150, 120, 150, 180, 120,
                                           150, 150, 150, 120, 150, 150};

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_WIDTH-1:0] csr_wdata;
   int                   outstanding;
   int                   mismatches;
   int                   send_idle_pct;
   int                   stall_pct;
   int                   cycle_count = 0;

   swm_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_chan ();
   swm_median_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_chan ();

   sliding_window_median #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   swm_median_checker #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) median_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_sample  (req_chan.sample),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_median  (rsp_chan.median),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly full-range values, some clustered for ties, some at the rails
   function automatic sample_type next_sample();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) return sample_type'($urandom);
      if (kind < 8) return sample_type'(int'($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 3))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   task automatic set_flow(input flow_mode_type mode);
      case (mode)
         FLOW_FREE: begin
            send_idle_pct <= 0;
            stall_pct     <= 0;
         end
         FLOW_SLOW_SENDER: begin
            send_idle_pct <= 80;
            stall_pct     <= 0;
         end
         FLOW_SLOW_RECEIVER: begin
            send_idle_pct <= 0;
            stall_pct     <= 80;
         end
         default: begin
            send_idle_pct <= 30;
            stall_pct     <= 30;
         end
      endcase
   endtask

   task automatic push_sample(input sample_type value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // stop sending, wait for every predicted median, then let the pipe empty
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [CSR_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] window;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window, zero window (acts as one), even window
      foreach (EDGE_SAMPLES[i]) push_sample(EDGE_SAMPLES[i]);
      drain_results();
      write_window(7'd0);
      foreach (SINGLE_SAMPLES[i]) push_sample(SINGLE_SAMPLES[i]);
      drain_results();
      write_window(7'd2);
      foreach (PAIR_SAMPLES[i]) push_sample(PAIR_SAMPLES[i]);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         if (p < FIXED_PHASES)
            window = CSR_WIDTH'(PHASE_WINDOW[p]);
         else if (p == FIXED_PHASES)
            window = CSR_WIDTH'($urandom_range(1, WINDOW_MAX));
         else
            window = CSR_WIDTH'($urandom_range(0, 127));
         set_flow(PHASE_FLOW[p]);
         write_window(window);
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            if (p == PAUSE_PHASE && i == PHASE_ITEMS[p] / 2) drain_results();
            push_sample(next_sample());
         end
      end

      drain_results();
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
